>>> src/rdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdf_pkg
// shared widths and constants for the regularized dipole field pipeline
// ----------------------------------------------------------------------------
package rdf_pkg;

  // default fraction bits of all fixed point values
  localparam int unsigned FRAC_BITS_DEF = 16;

  // coordinate and field width
  localparam int unsigned CW = 32;

  // intermediate width
  localparam int unsigned WW = 64;

  // three field components share one divisor
  localparam int unsigned LANES = 3;

  // integer square root of a WW bit value
  localparam int unsigned ROOT_W = WW / 2;

  // last quotient: enough bits to tell a saturated result from a fitting one
  localparam int unsigned Q3_W = CW + 1;

  // sign and zero flags of one point
  typedef struct packed {
    logic [LANES-1:0] neg;
    logic             zero;
  } sgn_t;

endpackage

>>> src/rdf_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdf_isqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module rdf_isqrt import rdf_pkg::*; #(
  parameter type tag_t = logic
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [WW-1:0]     rad_i,
  input  tag_t              tag_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [WW-1:0]     rad_o,
  output tag_t              tag_o
);

  logic          vld_q [ROOT_W];
  logic [WW-1:0] val_q [ROOT_W];
  logic [WW-1:0] res_q [ROOT_W];
  logic [WW-1:0] rad_q [ROOT_W];
  tag_t          tag_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam logic [WW-1:0] BitK = WW'(1) << (WW - 2 - 2 * k);
    logic          vld_in;
    logic [WW-1:0] val_in, res_in, rad_in, val_d, res_d;
    logic [WW:0]   trial;
    logic          ge;
    tag_t          tag_in;

    if (k == 0) begin : g_first
      assign vld_in = valid_i;
      assign val_in = rad_i;
      assign res_in = '0;
      assign rad_in = rad_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign val_in = val_q[k-1];
      assign res_in = res_q[k-1];
      assign rad_in = rad_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    assign trial = {1'b0, res_in} + {1'b0, BitK};
    assign ge    = {1'b0, val_in} >= trial;
    assign val_d = ge ? (val_in - trial[WW-1:0]) : val_in;
    assign res_d = ge ? ((res_in >> 1) + BitK) : (res_in >> 1);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      val_q[k] <= val_d;
      res_q[k] <= res_d;
      rad_q[k] <= rad_in;
      tag_q[k] <= tag_in;
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = res_q[ROOT_W-1][ROOT_W-1:0];
  assign rad_o   = rad_q[ROOT_W-1];
  assign tag_o   = tag_q[ROOT_W-1];

endmodule

>>> src/rdf_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdf_divider
// pipelined restoring divider, three lanes over one shared divisor
// ----------------------------------------------------------------------------
module rdf_divider import rdf_pkg::*; #(
  parameter int unsigned DW = 64,
  parameter int unsigned QW = 34,
  parameter type tag_t = logic
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [DW-1:0]            divisor_i,
  input  logic [LANES-1:0][DW-1:0] rem_i,
  input  logic [LANES-1:0][QW-1:0] bits_i,
  input  tag_t                     tag_i,
  output logic                     valid_o,
  output logic [DW-1:0]            divisor_o,
  output logic [LANES-1:0][QW-1:0] quot_o,
  output tag_t                     tag_o
);

  logic                     vld_q [QW];
  logic [DW-1:0]            dvs_q [QW];
  logic [LANES-1:0][DW-1:0] rem_q [QW];
  logic [LANES-1:0][QW-1:0] bit_q [QW];
  tag_t                     tag_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                     vld_in;
    logic [DW-1:0]            dvs_in;
    logic [LANES-1:0][DW-1:0] rem_in, rem_d;
    logic [LANES-1:0][QW-1:0] bit_in, bit_d;
    tag_t                     tag_in;

    if (k == 0) begin : g_first
      assign vld_in = valid_i;
      assign dvs_in = divisor_i;
      assign rem_in = rem_i;
      assign bit_in = bits_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign dvs_in = dvs_q[k-1];
      assign rem_in = rem_q[k-1];
      assign bit_in = bit_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    // shift in the next dividend bit, subtract if it fits
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DW:0] shifted, diff;
      assign shifted  = {rem_in[l], bit_in[l][QW-1]};
      assign diff     = shifted - {1'b0, dvs_in};
      assign rem_d[l] = diff[DW] ? shifted[DW-1:0] : diff[DW-1:0];
      assign bit_d[l] = {bit_in[l][QW-2:0], ~diff[DW]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dvs_q[k] <= dvs_in;
      rem_q[k] <= rem_d;
      bit_q[k] <= bit_d;
      tag_q[k] <= tag_in;
    end
  end

  assign valid_o   = vld_q[QW-1];
  assign divisor_o = dvs_q[QW-1];
  assign quot_o    = bit_q[QW-1];
  assign tag_o     = tag_q[QW-1];

endmodule

>>> src/regularized_dipole_field.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regularized_dipole_field
// softened dipole field B = (3xz, 3yz, 3z2 - r2 + 2d2) / (r2 + d2)^(5/2)
// ----------------------------------------------------------------------------
//
//  channel  | ports                                       | beat taken when
//  ---------+---------------------------------------------+-----------------------
//  point    | start, busy, pos_x_i, pos_y_i, pos_z_i      | start & !busy
//  field    | done_o, field_x_o, field_y_o, field_z_o,    | every cycle done_o is
//           | clipped_o                                   | high
//  config   | cfg_valid_i, cfg_ready_o,                   | cfg_valid_i &
//           | cfg_softening_squared_i                     | cfg_ready_o
//
// once busy is low one point enters per cycle, and every accepted point
// gives one field beat, in the order the points came in
// most of the depth is in the bit-per-stage units: a 32 stage square root,
// then three restoring dividers of 2*FRAC_BITS+2, 64 and 33 stages
// busy is high only during reset and the cycle after it
// the field beat is a one-cycle strobe; the receiver cannot hold it off,
// so the pipeline never stalls and every stage advances each cycle
//
// math on unsigned magnitudes with the sign applied at the end:
//   s  = x2 + y2 + z2 + (d2 << F),  q = floor(sqrt(s))
//   t1 = floor(m * 2^2F / s),  t2 = floor(t1 * 2^2F / s),  mag = floor(t2 / q)
// ----------------------------------------------------------------------------
module regularized_dipole_field import rdf_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // point channel
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] pos_x_i,
  input  logic signed [CW-1:0] pos_y_i,
  input  logic signed [CW-1:0] pos_z_i,
  // field channel
  output logic                 done_o,
  output logic signed [CW-1:0] field_x_o,
  output logic signed [CW-1:0] field_y_o,
  output logic signed [CW-1:0] field_z_o,
  output logic                 clipped_o,
  // configuration channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CW-1:0]        cfg_softening_squared_i
);

  // first quotient is at most 2^(2F+1)
  localparam int unsigned Q1_W  = 2 * FRAC_BITS + 2;
  localparam int unsigned SHIFT = 2 * FRAC_BITS;
  // 0.16 in fixed point, rounded
  localparam int unsigned D2_RESET = (16 * (2 ** FRAC_BITS) + 50) / 100;
  localparam int unsigned LAT = 4 + ROOT_W + Q1_W + 1 + WW + 1 + Q3_W + 1;

  typedef struct packed {
    logic [LANES-1:0][WW-1:0] num;
    sgn_t                     sg;
  } sq_tag_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    sgn_t              sg;
  } d1_tag_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    sgn_t              sg;
    logic [LANES-1:0]  ovf;
  } d2_tag_t;

  typedef struct packed {
    sgn_t             sg;
    logic [LANES-1:0] ovf;
  } d3_tag_t;

  // --------------------------------------------------------------------------
  // handshakes and the softening register
  // --------------------------------------------------------------------------
  logic          busy_q;
  logic [CW-1:0] cfg_q;
  logic          accept;

  assign busy        = busy_q;
  assign cfg_ready_o = ~busy_q;
  assign accept      = start & ~busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cfg_q  <= CW'(D2_RESET);
    end else begin
      busy_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_softening_squared_i;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: magnitudes and signs
  // --------------------------------------------------------------------------
  logic                     s1_vld_q;
  logic [LANES-1:0][CW-1:0] s1_mag_q, s1_mag_d;
  logic [LANES-1:0]         s1_neg_q, s1_neg_d;
  logic [LANES-1:0][CW-1:0] pos_raw;

  assign pos_raw = {pos_z_i, pos_y_i, pos_x_i};

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      s1_neg_d[l] = pos_raw[l][CW-1];
      s1_mag_d[l] = s1_neg_d[l] ? (~pos_raw[l] + CW'(1)) : pos_raw[l];
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: squares and cross products
  // --------------------------------------------------------------------------
  logic                     s2_vld_q;
  logic [LANES-1:0][WW-1:0] s2_sq_q, s2_sq_d;
  logic [WW-1:0]            s2_xz_q, s2_yz_q;
  logic [1:0]               s2_neg_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      s2_sq_d[l] = WW'(s1_mag_q[l]) * WW'(s1_mag_q[l]);
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: softened radius square and numerator parts
  // --------------------------------------------------------------------------
  logic          s3_vld_q;
  logic [WW-1:0] s3_s_q, s3_nx_q, s3_ny_q, s3_pz_q, s3_mz_q;
  logic [1:0]    s3_neg_q;
  logic          s3_zero_q;
  logic [WW-1:0] d2s;

  assign d2s = WW'(cfg_q) << FRAC_BITS;

  // --------------------------------------------------------------------------
  // stage 4: signed difference for the axial component
  // --------------------------------------------------------------------------
  logic          s4_vld_q;
  logic [WW-1:0] s4_s_q;
  sq_tag_t       s4_tag_q, s4_tag_d;

  always_comb begin
    s4_tag_d.num[0]  = s3_nx_q;
    s4_tag_d.num[1]  = s3_ny_q;
    s4_tag_d.sg.neg  = {~(s3_pz_q >= s3_mz_q), s3_neg_q};
    s4_tag_d.sg.zero = s3_zero_q;
    if (s3_pz_q >= s3_mz_q) begin
      s4_tag_d.num[2] = s3_pz_q - s3_mz_q;
    end else begin
      s4_tag_d.num[2] = s3_mz_q - s3_pz_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mag_q  <= s1_mag_d;
    s1_neg_q  <= s1_neg_d;
    s2_sq_q   <= s2_sq_d;
    s2_xz_q   <= WW'(s1_mag_q[0]) * WW'(s1_mag_q[2]);
    s2_yz_q   <= WW'(s1_mag_q[1]) * WW'(s1_mag_q[2]);
    s2_neg_q  <= {s1_neg_q[1] ^ s1_neg_q[2], s1_neg_q[0] ^ s1_neg_q[2]};
    s3_s_q    <= s2_sq_q[0] + s2_sq_q[1] + s2_sq_q[2] + d2s;
    s3_nx_q   <= (s2_xz_q << 1) + s2_xz_q;
    s3_ny_q   <= (s2_yz_q << 1) + s2_yz_q;
    s3_pz_q   <= (s2_sq_q[2] << 1) + (d2s << 1);
    s3_mz_q   <= s2_sq_q[0] + s2_sq_q[1];
    s3_neg_q  <= s2_neg_q;
    // zero softening at the origin: s is zero, the divider results are ignored and the field is forced to zero
    s3_zero_q <= ~|{s2_sq_q[0], s2_sq_q[1], s2_sq_q[2], cfg_q};
    s4_s_q    <= s3_s_q;
    s4_tag_q  <= s4_tag_d;
  end

  // --------------------------------------------------------------------------
  // square root of s
  // --------------------------------------------------------------------------
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  logic [WW-1:0]     sq_rad;
  sq_tag_t           sq_tag;

  rdf_isqrt #(
    .tag_t (sq_tag_t)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s4_vld_q),
    .rad_i   (s4_s_q),
    .tag_i   (s4_tag_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .rad_o   (sq_rad),
    .tag_o   (sq_tag)
  );

  // --------------------------------------------------------------------------
  // first division: t1 = m * 2^2F / s, never above 2^(2F+1)
  // --------------------------------------------------------------------------
  logic [LANES-1:0][WW-1:0]   d1_rem;
  logic [LANES-1:0][Q1_W-1:0] d1_bits;
  d1_tag_t                    d1_tag_in, d1_tag;
  logic                       d1_vld;
  logic [WW-1:0]              d1_dvs;
  logic [LANES-1:0][Q1_W-1:0] d1_quot;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      d1_rem[l]  = sq_tag.num[l] >> 2;
      d1_bits[l] = {sq_tag.num[l][1:0], SHIFT'(0)};
    end
    d1_tag_in.root = sq_root;
    d1_tag_in.sg   = sq_tag.sg;
  end

  rdf_divider #(
    .DW    (WW),
    .QW    (Q1_W),
    .tag_t (d1_tag_t)
  ) u_div1 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (sq_vld),
    .divisor_i (sq_rad),
    .rem_i     (d1_rem),
    .bits_i    (d1_bits),
    .tag_i     (d1_tag_in),
    .valid_o   (d1_vld),
    .divisor_o (d1_dvs),
    .quot_o    (d1_quot),
    .tag_o     (d1_tag)
  );

  // --------------------------------------------------------------------------
  // second division setup: quotient clamps at 64 bits, which saturates
  // any field that is not forced to zero, since the root stays below 2^32
  // --------------------------------------------------------------------------
  logic                     p5_vld_q;
  logic [WW-1:0]            p5_s_q;
  logic [LANES-1:0][WW-1:0] p5_rem_q, p5_rem_d;
  logic [LANES-1:0][WW-1:0] p5_bits_q, p5_bits_d;
  d2_tag_t                  p5_tag_q, p5_tag_d;

  always_comb begin
    logic [2*WW-1:0] n2;
    p5_tag_d.root = d1_tag.root;
    p5_tag_d.sg   = d1_tag.sg;
    for (int l = 0; l < LANES; l++) begin
      n2              = (2 * WW)'(d1_quot[l]) << SHIFT;
      p5_rem_d[l]     = n2[2*WW-1:WW];
      p5_bits_d[l]    = n2[WW-1:0];
      p5_tag_d.ovf[l] = n2[2*WW-1:WW] >= d1_dvs;
    end
  end

  always_ff @(posedge clk_i) begin
    p5_s_q    <= d1_dvs;
    p5_rem_q  <= p5_rem_d;
    p5_bits_q <= p5_bits_d;
    p5_tag_q  <= p5_tag_d;
  end

  logic                     d2_vld;
  logic [LANES-1:0][WW-1:0] d2_quot;
  d2_tag_t                  d2_tag;

  rdf_divider #(
    .DW    (WW),
    .QW    (WW),
    .tag_t (d2_tag_t)
  ) u_div2 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (p5_vld_q),
    .divisor_i (p5_s_q),
    .rem_i     (p5_rem_q),
    .bits_i    (p5_bits_q),
    .tag_i     (p5_tag_q),
    .valid_o   (d2_vld),
    .divisor_o (),
    .quot_o    (d2_quot),
    .tag_o     (d2_tag)
  );

  // --------------------------------------------------------------------------
  // third division setup: only 33 quotient bits matter for the rails
  // --------------------------------------------------------------------------
  logic                         p6_vld_q;
  logic [ROOT_W-1:0]            p6_root_q;
  logic [LANES-1:0][ROOT_W-1:0] p6_rem_q, p6_rem_d;
  logic [LANES-1:0][Q3_W-1:0]   p6_bits_q, p6_bits_d;
  d3_tag_t                      p6_tag_q, p6_tag_d;

  always_comb begin
    logic [WW-1:0] t2;
    p6_tag_d.sg = d2_tag.sg;
    for (int l = 0; l < LANES; l++) begin
      t2              = d2_tag.ovf[l] ? {WW{1'b1}} : d2_quot[l];
      p6_rem_d[l]     = ROOT_W'(t2[WW-1:Q3_W]);
      p6_bits_d[l]    = t2[Q3_W-1:0];
      p6_tag_d.ovf[l] = ROOT_W'(t2[WW-1:Q3_W]) >= d2_tag.root;
    end
  end

  always_ff @(posedge clk_i) begin
    p6_root_q <= d2_tag.root;
    p6_rem_q  <= p6_rem_d;
    p6_bits_q <= p6_bits_d;
    p6_tag_q  <= p6_tag_d;
  end

  logic                       d3_vld;
  logic [LANES-1:0][Q3_W-1:0] d3_quot;
  d3_tag_t                    d3_tag;

  rdf_divider #(
    .DW    (ROOT_W),
    .QW    (Q3_W),
    .tag_t (d3_tag_t)
  ) u_div3 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (p6_vld_q),
    .divisor_i (p6_root_q),
    .rem_i     (p6_rem_q),
    .bits_i    (p6_bits_q),
    .tag_i     (p6_tag_q),
    .valid_o   (d3_vld),
    .divisor_o (),
    .quot_o    (d3_quot),
    .tag_o     (d3_tag)
  );

  // --------------------------------------------------------------------------
  // sign, saturation and the output beat
  // --------------------------------------------------------------------------
  logic                     done_q;
  logic [LANES-1:0][CW-1:0] fld_q, fld_d;
  logic                     clip_q, clip_d;

  always_comb begin
    logic big;
    logic over;
    clip_d = 1'b0;
    over   = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      big = d3_tag.ovf[l] | d3_quot[l][Q3_W-1];
      if (d3_tag.sg.zero) begin
        fld_d[l] = '0;
      end else if (d3_tag.sg.neg[l]) begin
        // negative rail is one step further out
        over     = big | (d3_quot[l][CW-1] & |d3_quot[l][CW-2:0]);
        fld_d[l] = over ? {1'b1, {(CW-1){1'b0}}} : (~d3_quot[l][CW-1:0] + CW'(1));
        clip_d   = clip_d | over;
      end else begin
        over     = big | d3_quot[l][CW-1];
        fld_d[l] = over ? {1'b0, {(CW-1){1'b1}}} : d3_quot[l][CW-1:0];
        clip_d   = clip_d | over;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_vld_q <= 1'b0;
      p6_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      p5_vld_q <= d1_vld;
      p6_vld_q <= d2_vld;
      done_q   <= d3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    fld_q  <= fld_d;
    clip_q <= clip_d;
  end

  assign done_o    = done_q;
  assign field_x_o = fld_q[0];
  assign field_y_o = fld_q[1];
  assign field_z_o = fld_q[2];
  assign clipped_o = clip_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  localparam logic [CW-1:0] PosRail = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] NegRail = {1'b1, {(CW-1){1'b0}}};

  // every accepted point gives a beat after the fixed latency
  a_point_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("accepted point gave no field beat");

  // every beat belongs to a point accepted the fixed latency earlier
  a_beat_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("field beat does not match an accepted point");

  // a clipped beat has at least one component on a rail
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && clipped_o) |->
      (field_x_o == PosRail || field_x_o == NegRail ||
       field_y_o == PosRail || field_y_o == NegRail ||
       field_z_o == PosRail || field_z_o == NegRail))
    else $error("clipped set with no component saturated");

  // unclipped transverse components carry the sign of x*z and y*z
  a_sign_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !clipped_o && field_x_o != '0) |->
      field_x_o[CW-1] == $past(pos_x_i[CW-1] ^ pos_z_i[CW-1], LAT))
    else $error("field_x sign mismatch");

  a_sign_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !clipped_o && field_y_o != '0) |->
      field_y_o[CW-1] == $past(pos_y_i[CW-1] ^ pos_z_i[CW-1], LAT))
    else $error("field_y sign mismatch");

endmodule
